>>> rtl/ptds_pkg.sv
// Shared types and constants for the periodic task deadline scheduler.
`default_nettype none
package ptds_pkg;

  localparam logic [1:0] CMD_SELECT = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] REG_TASK_COUNT = 3'd0;
  localparam logic [2:0] REG_CATCH_UP   = 3'd1;
  localparam logic [2:0] REG_PERIOD0    = 3'd2;
  localparam int         NUM_PERIOD_REGS = 4;

  localparam logic [31:0] PERIOD_RESET = 32'd1000000000;
  localparam int          DIV_STEPS    = 48;

  typedef struct packed {
    logic latch_in;
    logic scan_init;
    logic scan_step;
    logic pick_best;
    logic read_sel;
    logic charge;
    logic div_init;
    logic div_step;
    logic upd_due;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       n_zero;
    logic       scan_last;
    logic       catch_div;
    logic       div_last;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/ptds_ctrl.sv
// Sequencer for the scheduler: decode, scan, pick, charge, divide, due-update and output steps.
`default_nettype none
module ptds_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  ptds_pkg::dp_status_t status,
  output ptds_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_PICK   = 3'd3;
  localparam logic [2:0] ST_CHARGE = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_UPD    = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.command)
          ptds_pkg::CMD_SELECT, ptds_pkg::CMD_REPORT: begin
            cmd.scan_init = 1'b1;
            state_next = status.n_zero ? ST_OUT : ST_SCAN;
          end
          ptds_pkg::CMD_READ: begin
            cmd.read_sel = 1'b1;
            state_next = ST_OUT;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick_best = 1'b1;
        state_next = (status.command == ptds_pkg::CMD_REPORT) ? ST_CHARGE : ST_OUT;
      end
      ST_CHARGE: begin
        cmd.charge = 1'b1;
        if (status.catch_div) begin
          cmd.div_init = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_UPD;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd_due = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ptds_dp.sv
// Datapath: task state, config registers, scan, remainder divider, output register.
`default_nettype none
module ptds_dp #(
  parameter int MAX_TASKS = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_index,
  input  wire  [31:0]          cfg_data,
  input  wire  [1:0]           s_tuser,
  input  wire  [151:0]         s_tdata,
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [167:0]         m_tdata,
  input  ptds_pkg::ctrl_cmd_t  cmd,
  output ptds_pkg::dp_status_t status
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic [2:0]  tcount;
  logic [3:0]  catch_mask;
  logic [31:0] period [MAX_TASKS];

  logic [47:0] next_due [MAX_TASKS];
  logic [31:0] runs     [MAX_TASKS];
  logic [31:0] overruns [MAX_TASKS];
  logic [47:0] max_late [MAX_TASKS];

  logic [1:0]  command_q;
  logic [47:0] start_q, run_q, finish_q;
  logic [1:0]  sel_q;

  logic [IW-1:0] scan_i, idx, best_idx, rd_idx;
  logic [47:0]   best_due;
  logic          empty_q, missed_q;

  logic [31:0] rem;
  logic [47:0] dvd;
  logic [5:0]  div_cnt;

  logic [4:0]  n_en;
  logic [47:0] due_rd;
  logic [31:0] per_rd, p_eff;
  logic        cu_policy, fin_ge_due;
  logic        miss, over;
  logic [47:0] late, excess, m1, m2;
  logic [31:0] o1, o2;
  logic [32:0] trial;
  logic [47:0] due_new;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  always_comb begin
    if ({2'b0, tcount} > 5'(MAX_TASKS)) n_en = 5'(MAX_TASKS);
    else n_en = {2'b0, tcount};
    rd_idx = cmd.scan_step ? scan_i : idx;
    due_rd = next_due[rd_idx];
    per_rd = period[rd_idx];
    p_eff = (per_rd == 32'd0) ? 32'd1 : per_rd;
    cu_policy = (32'(idx) < 32'd4) ? catch_mask[2'(idx)] : 1'b0;
    fin_ge_due = finish_q >= due_rd;
    miss = start_q > due_rd;
    late = start_q - due_rd;
    over = run_q > {16'b0, p_eff};
    excess = run_q - {16'b0, p_eff};
    o1 = miss ? sat_inc(overruns[idx]) : overruns[idx];
    o2 = over ? sat_inc(o1) : o1;
    m1 = (miss && late > max_late[idx]) ? late : max_late[idx];
    m2 = (over && excess > m1) ? excess : m1;
    trial = {rem, dvd[47]};
    if (cu_policy && fin_ge_due) due_new = finish_q + {16'b0, p_eff} - {16'b0, rem};
    else if (cu_policy) due_new = due_rd + {16'b0, p_eff};
    else due_new = finish_q + {16'b0, p_eff};
    status.command = command_q;
    status.n_zero = (n_en == 5'd0);
    status.scan_last = (5'(scan_i) + 5'd1 == n_en);
    status.catch_div = cu_policy && fin_ge_due;
    status.div_last = (div_cnt == 6'(ptds_pkg::DIV_STEPS - 1));
    status.out_free = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tcount <= '0;
      catch_mask <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        period[i] <= ptds_pkg::PERIOD_RESET;
        next_due[i] <= {16'b0, ptds_pkg::PERIOD_RESET};
        runs[i] <= '0;
        overruns[i] <= '0;
        max_late[i] <= '0;
      end
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ptds_pkg::REG_TASK_COUNT) tcount <= cfg_data[2:0];
        else if (cfg_index == ptds_pkg::REG_CATCH_UP) catch_mask <= cfg_data[3:0];
        else begin
          for (int i = 0; i < MAX_TASKS && i < ptds_pkg::NUM_PERIOD_REGS; i++) begin
            if (cfg_index == ptds_pkg::REG_PERIOD0 + 3'(i)) period[i] <= cfg_data;
          end
        end
      end
      if (cmd.charge) begin
        runs[idx] <= sat_inc(runs[idx]);
        overruns[idx] <= o2;
        max_late[idx] <= m2;
      end
      if (cmd.upd_due) next_due[idx] <= due_new;
      if (cmd.load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      command_q <= s_tuser;
      start_q <= s_tdata[47:0];
      run_q <= s_tdata[95:48];
      finish_q <= s_tdata[143:96];
      sel_q <= s_tdata[145:144];
      empty_q <= 1'b0;
      missed_q <= 1'b0;
    end
    if (cmd.scan_init) begin
      scan_i <= '0;
      empty_q <= (n_en == 5'd0);
    end
    if (cmd.scan_step) begin
      if (scan_i == '0 || due_rd < best_due) begin
        best_due <= due_rd;
        best_idx <= scan_i;
      end
      scan_i <= scan_i + 1'b1;
    end
    if (cmd.pick_best) idx <= best_idx;
    if (cmd.read_sel) begin
      idx <= IW'(sel_q);
      empty_q <= (32'(sel_q) >= 32'(MAX_TASKS));
    end
    if (cmd.charge) missed_q <= miss;
    if (cmd.div_init) begin
      dvd <= finish_q - due_rd;
      rem <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, p_eff}) rem <= 32'(trial - {1'b0, p_eff});
      else rem <= trial[31:0];
      dvd <= {dvd[46:0], 1'b0};
      div_cnt <= div_cnt + 6'd1;
    end
    if (cmd.load_out) begin
      if (empty_q) m_tdata <= {165'b0, 1'b1, 2'b0};
      else m_tdata <= {4'b0, max_late[idx], overruns[idx], runs[idx], missed_q,
                       next_due[idx], 1'b0, 2'(idx)};
    end
  end

endmodule
`default_nettype wire

>>> rtl/periodic_task_deadline_scheduler.sv
// Top level of the periodic task deadline scheduler.
// Input stream: s_tuser carries the command (0 select, 1 report, 2 read);
// s_tdata carries start_time, run_time, finish_time and task_select.
// Output stream: one transfer per select, report or read command; command 3
// is dropped without a result.
// Config: cfg_we writes cfg_data to register cfg_index (0 task count,
// 1 catch-up mask, 2..5 periods) on the clock edge; write only while idle.
// Steps: a select scans the task slots, one slot per cycle, and picks the
// earliest due; a report also charges that task and updates its due time;
// a catch-up report with finish at or after the due time first forms the
// bit-serial remainder of finish minus due by the period. Read and no-task
// skip the scan. One item is processed at a time; the next is accepted in the
// cycle after the result is loaded into the output register, which holds it
// while m_tready is low; a finished item then waits, with s_tready low.
// Reset (rst, synchronous) clears statistics, sets each due time and
// period to one second, task count and mask to zero.
`default_nettype none
module periodic_task_deadline_scheduler #(
  parameter int MAX_TASKS = 4
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_we,
  input  wire  [2:0]   cfg_index,
  input  wire  [31:0]  cfg_data,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [1:0]   s_tuser,  // command
  input  wire  [151:0] s_tdata,  // start_time, run_time, finish_time, task_select
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [167:0] m_tdata   // task_index, no_task, due_time, missed,
                                 // run_count, overrun_count, worst_lateness
);

  ptds_pkg::ctrl_cmd_t  cmd;
  ptds_pkg::dp_status_t status;

  ptds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ptds_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

>>> tb/periodic_task_deadline_scheduler_test.sv
// Testbench for the periodic task deadline scheduler: directed and random commands, checked against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_deadline_scheduler_test;

  localparam int NT = 4;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  typedef struct packed {
    logic [47:0] worst_lateness;
    logic [31:0] overrun_count;
    logic [31:0] run_count;
    logic        missed;
    logic [47:0] due_time;
    logic        no_task;
    logic [1:0]  task_index;
  } sched_result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [1:0] s_tuser = '0;
  logic [151:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [167:0] m_tdata;

  periodic_task_deadline_scheduler dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [2:0] task_count_q;
  logic [3:0] catch_up_q;
  logic [31:0] period_q [NT];
  logic [47:0] next_due_q [NT];
  logic [31:0] runs_q [NT];
  logic [31:0] overruns_q [NT];
  logic [47:0] max_late_q [NT];

  sched_result_t expected_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int reports_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int earliest_task();
    int n;
    int best;
    n = (int'(task_count_q) > NT) ? NT : int'(task_count_q);
    best = -1;
    for (int i = 0; i < n; i++)
      if (best < 0 || next_due_q[i] < next_due_q[best]) best = i;
    return best;
  endfunction

  function automatic sched_result_t task_stats(input int i, input logic miss);
    sched_result_t r;
    r.task_index = i[1:0];
    r.no_task = 1'b0;
    r.due_time = next_due_q[i];
    r.missed = miss;
    r.run_count = runs_q[i];
    r.overrun_count = overruns_q[i];
    r.worst_lateness = max_late_q[i];
    return r;
  endfunction

  task automatic queue_expected(input sched_result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic predict_command(input logic [1:0] cmd, input logic [47:0] start,
                                 input logic [47:0] run, input logic [47:0] finish,
                                 input logic [1:0] sel);
    sched_result_t none;
    int t;
    logic [47:0] p;
    logic [47:0] due;
    logic miss;
    logic [47:0] k;
    logic [95:0] prod;
    none = '0;
    none.no_task = 1'b1;
    if (cmd == ptds_pkg::CMD_READ) begin
      queue_expected(task_stats(int'(sel), 1'b0));
      return;
    end
    if (cmd == CMD_IGNORED) return;
    t = earliest_task();
    if (t < 0) begin
      queue_expected(none);
      return;
    end
    if (cmd == ptds_pkg::CMD_SELECT) begin
      queue_expected(task_stats(t, 1'b0));
      return;
    end
    p = (period_q[t] == 32'd0) ? 48'd1 : {16'd0, period_q[t]};
    due = next_due_q[t];
    miss = start > due;
    runs_q[t] = sat_inc(runs_q[t]);
    if (miss) begin
      overruns_q[t] = sat_inc(overruns_q[t]);
      if (start - due > max_late_q[t]) max_late_q[t] = start - due;
    end
    if (run > p) begin
      overruns_q[t] = sat_inc(overruns_q[t]);
      if (run - p > max_late_q[t]) max_late_q[t] = run - p;
    end
    if (catch_up_q[t]) begin
      k = 48'd1;
      if (finish >= due) k = (finish - due) / p + 48'd1;
      prod = k * p;
      next_due_q[t] = due + prod[47:0];
    end else begin
      next_due_q[t] = finish + p;
    end
    queue_expected(task_stats(t, miss));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ptds_pkg::REG_TASK_COUNT) task_count_q = val[2:0];
    else if (idx == ptds_pkg::REG_CATCH_UP) catch_up_q = val[3:0];
    else if (idx >= ptds_pkg::REG_PERIOD0 &&
             int'(idx) < int'(ptds_pkg::REG_PERIOD0) + ptds_pkg::NUM_PERIOD_REGS)
      period_q[2'(idx - ptds_pkg::REG_PERIOD0)] = val;
  endtask

  // drive at falling edge, wait for acceptance at the rising edge
  task automatic send_command(input logic [1:0] cmd, input logic [47:0] start,
                              input logic [47:0] run, input logic [47:0] finish,
                              input logic [1:0] sel);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {6'b0, sel, finish, run, start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_command(cmd, start, run, finish, sel);
    items_sent++;
    if (cmd == ptds_pkg::CMD_REPORT) reports_sent++;
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (80) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      m_tready <= 1'b0;
      hold_off_cycles--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[163:0];
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx=%0d none=%0d due=%h miss=%0d runs=%h ovr=%h late=%h | got idx=%0d none=%0d due=%h miss=%0d runs=%h ovr=%h late=%h",
              want.task_index, want.no_task, want.due_time, want.missed, want.run_count,
              want.overrun_count, want.worst_lateness, got.task_index, got.no_task,
              got.due_time, got.missed, got.run_count, got.overrun_count,
              got.worst_lateness);
        end
      end
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] near(input logic [47:0] base, input int span);
    return base + 48'($urandom_range(2 * span)) - 48'(span);
  endfunction

  task automatic test_directed();
    write_reg(ptds_pkg::REG_TASK_COUNT, 32'd0);
    send_command(ptds_pkg::CMD_SELECT, '0, '0, '0, '0);
    send_command(ptds_pkg::CMD_REPORT, M48, M48, M48, 2'd3);
    send_command(ptds_pkg::CMD_READ, '0, '0, '0, 2'd3);
    send_command(CMD_IGNORED, M48, M48, M48, 2'd3);
    drain();
    write_reg(ptds_pkg::REG_TASK_COUNT, 32'd7);
    write_reg(ptds_pkg::REG_CATCH_UP, 32'hA);
    write_reg(ptds_pkg::REG_PERIOD0, 32'd0);
    write_reg(ptds_pkg::REG_PERIOD0 + 3'd1, 32'hFFFF_FFFF);
    write_reg(ptds_pkg::REG_PERIOD0 + 3'd2, 32'd1);
    write_reg(ptds_pkg::REG_PERIOD0 + 3'd3, 32'd1000);
    send_command(ptds_pkg::CMD_SELECT, '0, '0, '0, '0);
    send_command(ptds_pkg::CMD_REPORT, M48, M48, M48, '0);
    send_command(ptds_pkg::CMD_REPORT, '0, '0, '0, '0);
    send_command(ptds_pkg::CMD_REPORT, 48'd1000000001, 48'd5000, 48'd1000002000, '0);
    send_command(ptds_pkg::CMD_REPORT, 48'd999999999, 48'd10, 48'd2999999999, '0);
    send_command(ptds_pkg::CMD_SELECT, '0, '0, '0, '0);
    for (int i = 0; i < 4; i++) send_command(ptds_pkg::CMD_READ, '0, '0, '0, i[1:0]);
    send_command(CMD_IGNORED, '0, '0, '0, '0);
    send_command(ptds_pkg::CMD_REPORT, M48, '0, '0, '0);
    send_command(ptds_pkg::CMD_REPORT, '0, M48, '0, '0);
    drain();
  endtask

  task automatic test_random(input int count);
    logic [1:0] cmd;
    logic [47:0] base;
    int t;
    for (int n = 0; n < count; n++) begin
      if (n % 300 == 0) begin
        drain();
        write_reg(ptds_pkg::REG_TASK_COUNT, $urandom_range(7));
        write_reg(ptds_pkg::REG_CATCH_UP, $urandom_range(15));
        for (int i = 0; i < 4; i++)
          write_reg(ptds_pkg::REG_PERIOD0 + 3'(i), ($urandom_range(9) == 0) ? $urandom() :
                    ($urandom_range(5) == 0 ? 32'd0 : $urandom_range(5000)));
      end
      cmd = $urandom_range(99) < 55 ? ptds_pkg::CMD_REPORT :
            ($urandom_range(2) == 0 ? ptds_pkg::CMD_SELECT :
             ($urandom_range(9) == 0 ? CMD_IGNORED : ptds_pkg::CMD_READ));
      t = earliest_task();
      base = (t >= 0) ? next_due_q[t] : rand48();
      if ($urandom_range(9) == 0)
        send_command(cmd, rand48(), rand48(), rand48(), 2'($urandom_range(3)));
      else
        send_command(cmd, near(base, 3000), 48'($urandom_range(8000)),
                     near(base, 20000), 2'($urandom_range(3)));
      if (n == count / 2) begin
        hold_off_cycles = 400;
        for (int j = 0; j < 6; j++) send_command(ptds_pkg::CMD_SELECT, '0, '0, '0, '0);
        drain();
      end
    end
    drain();
  endtask

  task automatic test_saturation();
    write_reg(ptds_pkg::REG_TASK_COUNT, 32'd1);
    write_reg(ptds_pkg::REG_CATCH_UP, 32'd0);
    write_reg(ptds_pkg::REG_PERIOD0, 32'd1);
    for (int i = 0; i < 20; i++) send_command(ptds_pkg::CMD_REPORT, M48, M48, '0, '0);
    drain();
  endtask

  initial begin
    for (int i = 0; i < NT; i++) begin
      period_q[i] = ptds_pkg::PERIOD_RESET;
      next_due_q[i] = {16'd0, ptds_pkg::PERIOD_RESET};
      runs_q[i] = '0;
      overruns_q[i] = '0;
      max_late_q[i] = '0;
    end
    task_count_q = '0;
    catch_up_q = '0;
    repeat (3) @(negedge clk);
    rst <= 0;
    test_directed();
    send_idle_pct = 18; recv_idle_pct = 63;
    test_random(630);
    send_idle_pct = 63; recv_idle_pct = 18;
    test_random(630);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(630);
    test_saturation();
    $display("Sent %0d commands (%0d reports), checked %0d results across",
             items_sent, reports_sent, results_seen);
    $display("skip and catch-up policies, zero and extreme periods, and output back-pressure.");
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/ptds_pkg.sv
rtl/ptds_ctrl.sv
rtl/ptds_dp.sv
rtl/periodic_task_deadline_scheduler.sv
tb/periodic_task_deadline_scheduler_test.sv
